// ----- hw/rtl/potc_pkg.sv -----
`default_nettype none
package potc_pkg;

   localparam int SymW = 8;

   typedef enum logic [1:0] {
      VERDICT_TOTAL         = 2'd0,
      VERDICT_INCOMPLETE    = 2'd1,
      VERDICT_CONTRADICTORY = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [7:0] first_symbol;
      logic [7:0] second_symbol;
      logic       last_pair;
   } req_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic [8:0] symbol_count;
      logic       pairs_dropped;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic store;       // write accepted pair
      logic clr_start;   // restart clear sweep
      logic clr_step;    // clear one rank entry
      logic seen_start;  // restart pair walk for seen marking
      logic seen_step;   // issue one pair read, mark seen
      logic rnd_start;   // start a relaxation round
      logic rnd_step;    // relax one pair
      logic hit_start;   // restart hit histogram sweep
      logic hit_step;    // count one symbol
      logic chk_start;   // restart rank uniqueness sweep
      logic chk_step;    // check one rank
      logic finish;      // capture result, reset set state
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic clr_done;
      logic seen_done;
      logic rnd_done;
      logic rnd_changed;
      logic contra;
      logic hit_done;
      logic chk_done;
      logic chk_bad;
   } sts_type;

endpackage
`default_nettype wire

// ----- hw/rtl/potc_datapath.sv -----
`default_nettype none
module potc_datapath
   import potc_pkg::*;
#(
   parameter int MAX_PAIRS    = 256,
   parameter int SYMBOL_COUNT = 256
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_in,
   input  wire cmd_type cmd,
   output sts_type      sts,
   output rsp_type      rsp_data
);

   localparam int PW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int SW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int CW = $clog2(MAX_PAIRS + 1);
   localparam int KW = $clog2(SYMBOL_COUNT + 1);
   localparam int RW = 9;

   logic [2*SW-1:0] pair_mem [MAX_PAIRS];
   logic [RW-1:0]   rank_mem [SYMBOL_COUNT];
   logic            seen_mem [SYMBOL_COUNT];
   logic [RW-1:0]   hits_mem [SYMBOL_COUNT];

   logic [CW-1:0] pcount_ff, pcount_in;
   logic          ovf_ff, ovf_in;
   logic [KW-1:0] count_ff;
   logic [CW-1:0] idx_ff;       // pair index or sweep index
   logic [KW-1:0] sidx_ff;
   logic [1:0]    ph_ff;        // per-pair sub-step
   logic [2*SW-1:0] pr_ff;
   logic [RW-1:0] ra_ff, rb_ff;
   logic          sb_ff, sa_ff;
   logic          changed_ff, contra_ff, bad_ff;
   rsp_type       rsp_ff;

   logic [SW-1:0] fa, fb;
   assign fa = SW'(req_in.first_symbol % SYMBOL_COUNT);
   assign fb = SW'(req_in.second_symbol % SYMBOL_COUNT);

   logic [SW-1:0] pa, pb;
   assign pa = pr_ff[2*SW-1:SW];
   assign pb = pr_ff[SW-1:0];

   logic [RW:0] up, mx;
   assign up = {1'b0, ra_ff} + 1'b1;
   assign mx = (up > {1'b0, rb_ff}) ? up : {1'b0, rb_ff};

   always_comb begin
      pcount_in = pcount_ff;
      ovf_in    = ovf_ff;
      if (cmd.store) begin
         if (pcount_ff < CW'(MAX_PAIRS)) pcount_in = pcount_ff + 1'b1;
         else ovf_in = 1'b1;
      end
      if (cmd.finish) begin
         pcount_in = '0;
         ovf_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         pcount_ff <= pcount_in;
         ovf_ff    <= ovf_in;
      end
   end

   // Pair store write.
   always_ff @(posedge clock) begin
      if (cmd.store && pcount_ff < CW'(MAX_PAIRS))
         pair_mem[pcount_ff[PW-1:0]] <= {fa, fb};
   end

   // Sequenced walks; pair read, then rank reads, then rank write.
   always_ff @(posedge clock) begin
      if (cmd.clr_start || cmd.hit_start || cmd.chk_start) begin
         sidx_ff <= '0;
         bad_ff  <= 1'b0;
      end
      if (cmd.clr_start) count_ff <= '0;
      if (cmd.seen_start || cmd.rnd_start) begin
         idx_ff <= '0;
         ph_ff  <= 2'd0;
      end
      if (cmd.rnd_start) begin
         changed_ff <= 1'b0;
         contra_ff  <= 1'b0;
      end
      if (cmd.clr_step) begin
         rank_mem[sidx_ff[SW-1:0]] <= '0;
         seen_mem[sidx_ff[SW-1:0]] <= 1'b0;
         hits_mem[sidx_ff[SW-1:0]] <= '0;
         sidx_ff <= sidx_ff + 1'b1;
      end
      if (cmd.seen_step) begin
         case (ph_ff)
            2'd0: begin
               pr_ff <= pair_mem[idx_ff[PW-1:0]];
               ph_ff <= 2'd1;
            end
            2'd1: begin
               sa_ff <= seen_mem[pa];
               ph_ff <= 2'd2;
            end
            2'd2: begin
               if (!sa_ff) count_ff <= count_ff + 1'b1;
               seen_mem[pa] <= 1'b1;
               // Second symbol counts as seen when it equals the first.
               sb_ff <= seen_mem[pb] || (pa == pb);
               ph_ff <= 2'd3;
            end
            default: begin
               if (!sb_ff) count_ff <= count_ff + 1'b1;
               seen_mem[pb] <= 1'b1;
               ph_ff  <= 2'd0;
               idx_ff <= idx_ff + 1'b1;
            end
         endcase
      end
      if (cmd.rnd_step) begin
         case (ph_ff)
            2'd0: begin
               pr_ff <= pair_mem[idx_ff[PW-1:0]];
               ph_ff <= 2'd1;
            end
            2'd1: begin
               ra_ff <= rank_mem[pa];
               rb_ff <= rank_mem[pb];
               ph_ff <= 2'd2;
            end
            default: begin
               if (count_ff == '0 || mx > (RW+1)'(count_ff) - 1'b1) begin
                  contra_ff <= 1'b1;
               end else if (mx[RW-1:0] != rb_ff) begin
                  rank_mem[pb] <= mx[RW-1:0];
                  changed_ff   <= 1'b1;
               end
               ph_ff  <= 2'd0;
               idx_ff <= idx_ff + 1'b1;
            end
         endcase
      end
      if (cmd.hit_step) begin
         // Read rank and seen, then read the hit entry, then bump it.
         if (ph_ff == 2'd0) begin
            ra_ff <= rank_mem[sidx_ff[SW-1:0]];
            sa_ff <= seen_mem[sidx_ff[SW-1:0]];
            ph_ff <= 2'd1;
         end else if (ph_ff == 2'd1) begin
            rb_ff <= hits_mem[ra_ff[SW-1:0]];
            ph_ff <= 2'd2;
         end else begin
            if (sa_ff && ra_ff < RW'(SYMBOL_COUNT))
               hits_mem[ra_ff[SW-1:0]] <= rb_ff + 1'b1;
            ph_ff   <= 2'd0;
            sidx_ff <= sidx_ff + 1'b1;
         end
      end
      if (cmd.chk_step) begin
         if (ph_ff == 2'd0) begin
            rb_ff <= hits_mem[sidx_ff[SW-1:0]];
            ph_ff <= 2'd1;
         end else begin
            if (rb_ff != RW'(1)) bad_ff <= 1'b1;
            ph_ff   <= 2'd0;
            sidx_ff <= sidx_ff + 1'b1;
         end
      end
      if (cmd.hit_start || cmd.chk_start) ph_ff <= 2'd0;
      if (cmd.finish) begin
         rsp_ff.verdict <= contra_ff ? VERDICT_CONTRADICTORY :
                           (bad_ff ? VERDICT_INCOMPLETE : VERDICT_TOTAL);
         rsp_ff.symbol_count  <= 9'(count_ff);
         rsp_ff.pairs_dropped <= ovf_ff;
      end
   end

   logic [KW-1:0] chk_lim;
   assign chk_lim = (count_ff < KW'(SYMBOL_COUNT)) ? count_ff : KW'(SYMBOL_COUNT);

   assign sts.clr_done    = (sidx_ff == KW'(SYMBOL_COUNT));
   assign sts.seen_done   = (idx_ff == pcount_ff);
   assign sts.rnd_done    = (idx_ff == pcount_ff) || contra_ff;
   assign sts.rnd_changed = changed_ff;
   assign sts.contra      = contra_ff;
   assign sts.hit_done    = (sidx_ff == KW'(SYMBOL_COUNT));
   assign sts.chk_done    = (sidx_ff == chk_lim) || bad_ff;
   assign sts.chk_bad     = bad_ff;
   assign rsp_data        = rsp_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/potc_ctrl.sv -----
`default_nettype none
module potc_ctrl
   import potc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_last,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [7:0] {
      ST_LOAD  = 8'b0000_0001,
      ST_CLR   = 8'b0000_0010,
      ST_SEEN  = 8'b0000_0100,
      ST_RND   = 8'b0000_1000,
      ST_RNDX  = 8'b0001_0000,
      ST_HIT   = 8'b0010_0000,
      ST_CHK   = 8'b0100_0000,
      ST_FIN   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      vld_ff, vld_in;
   logic      acc;

   assign req_ready = (state_ff == ST_LOAD) && !vld_ff;
   assign acc       = req_valid && req_ready;
   assign rsp_valid = vld_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      vld_in   = vld_ff && !rsp_ready;
      unique case (state_ff)
         ST_LOAD: begin
            cmd.store = acc;
            if (acc && req_last) begin
               cmd.clr_start = 1'b1;
               state_in      = ST_CLR;
            end
         end
         ST_CLR: begin
            if (sts.clr_done) begin
               cmd.seen_start = 1'b1;
               state_in       = ST_SEEN;
            end else cmd.clr_step = 1'b1;
         end
         ST_SEEN: begin
            if (sts.seen_done) begin
               cmd.rnd_start = 1'b1;
               state_in      = ST_RND;
            end else cmd.seen_step = 1'b1;
         end
         ST_RND: begin
            if (sts.rnd_done) state_in = ST_RNDX;
            else cmd.rnd_step = 1'b1;
         end
         ST_RNDX: begin
            if (sts.contra) state_in = ST_FIN;
            else if (sts.rnd_changed) begin
               cmd.rnd_start = 1'b1;
               state_in      = ST_RND;
            end else begin
               cmd.hit_start = 1'b1;
               state_in      = ST_HIT;
            end
         end
         ST_HIT: begin
            if (sts.hit_done) begin
               cmd.chk_start = 1'b1;
               state_in      = ST_CHK;
            end else cmd.hit_step = 1'b1;
         end
         ST_CHK: begin
            if (sts.chk_done) state_in = ST_FIN;
            else cmd.chk_step = 1'b1;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            vld_in     = 1'b1;
            state_in   = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/partial_order_total_check.sv -----
`default_nettype none
// Partial order total check.
// Input channel req_: one beat per "first precedes second" pair; last_pair
// closes the set and starts the check. Result channel rsp_: one beat per set
// with verdict (total, incomplete, contradictory), distinct symbol count and
// a flag for pairs dropped because the pair store was full.
// Throughput: ordinary pairs load one per cycle while no check runs and no
// result waits. The last pair starts the check, which walks single-port
// tables over the P stored pairs: a clear sweep, seen marking, relaxation
// rounds (a contradiction ends the round early), a rank histogram sweep and
// a uniqueness check over up to count ranks, then the result register loads.
// Rounds run until settled.
// Reset clears the controller and pair count; tables are cleared per check.
// While the result beat waits on rsp_ready, req_ready stays low and all
// state holds; the next set loads once the result is taken.
module partial_order_total_check
   import potc_pkg::*;
#(
   parameter int MAX_PAIRS    = 256,
   parameter int SYMBOL_COUNT = 256
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   cmd_type cmd;
   sts_type sts;

   // Sequence the check phases.
   potc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_pair),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Hold the pair store, rank tables and result register.
   potc_datapath #(
      .MAX_PAIRS    (MAX_PAIRS),
      .SYMBOL_COUNT (SYMBOL_COUNT)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_in   (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

// ----- hw/rtl/potc_checker.sv -----
`default_nettype none
module potc_checker
   import potc_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   a_verdict_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.verdict != 2'd3)
      else $error("illegal verdict");

   a_no_accept_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input accepted while result pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last_pair |=> !req_ready)
      else $error("ready after last pair");

endmodule

bind partial_order_total_check potc_checker u_potc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
